// ===== hw/rtl/rcf_pkg.sv =====
// rcf_pkg: shared types and constants for the relayed circuit credit block.
// Holds the transaction structs, command codes, poll bits and status codes.
// No dependencies.
`timescale 1ns / 1ps

package rcf_pkg;

  // Command codes carried in the cmd field
  localparam logic [3:0] CMD_DATA     = 4'd0;
  localparam logic [3:0] CMD_ACCEPT   = 4'd1;
  localparam logic [3:0] CMD_CREDIT   = 4'd2;
  localparam logic [3:0] CMD_CLOSED   = 4'd3;
  localparam logic [3:0] CMD_WRITABLE = 4'd4;
  localparam logic [3:0] CMD_READ     = 4'd5;
  localparam logic [3:0] CMD_WRITE    = 4'd6;
  localparam logic [3:0] CMD_SHUTDOWN = 4'd7;
  localparam logic [3:0] CMD_RELEASE  = 4'd8;

  // Poll event bits
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_IN   = 3'd1;
  localparam logic [2:0] EV_OUT  = 3'd2;
  localparam logic [2:0] EV_ERR  = 3'd4;

  // Access status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BLOCK  = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  localparam logic [31:0] DEFAULT_WINDOW        = 32'd65536;
  localparam logic [3:0]  PROTOCOL_ERROR_REASON = 4'd1;
  localparam logic [31:0] U32_MAX               = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] amount;
    logic        orderly;
    logic [3:0]  reason_in;
    logic        want_write;
    logic        carrier_ok;
  } rcf_in_t;

  typedef struct packed {
    logic [2:0]  poll_events;
    logic [31:0] io_count;
    logic [1:0]  io_status;
    logic        grant_valid;
    logic [31:0] grant_bytes;
    logic        data_sent;
    logic        close_sent_now;
    logic [3:0]  close_reason;
    logic        release_notice;
  } rcf_out_t;

  // Circuit flags exported from the engine
  typedef struct packed {
    logic closed;
    logic released;
    logic credit_blocked;
    logic carrier_blocked;
  } rcf_status_t;

endpackage

// ===== hw/rtl/rcf_engine.sv =====
// rcf_engine: circuit state, window and credit registers plus the event logic.
// Computes one result per fired transaction in a single pass.
// Depends on rcf_pkg.
`timescale 1ns / 1ps

module rcf_engine #(
  parameter int unsigned MAX_CHUNK     = 16384,
  parameter int unsigned GRANT_DIVISOR = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               fire_i,
  input  rcf_pkg::rcf_in_t   ev_i,
  output rcf_pkg::rcf_out_t  res_o,
  output rcf_pkg::rcf_status_t status_o
);
  import rcf_pkg::*;

  localparam int unsigned GD_W = $clog2(GRANT_DIVISOR + 1);
  localparam int unsigned PW   = 32 + GD_W;
  localparam logic [31:0] GD_M1 = 32'(GRANT_DIVISOR - 1);
  localparam logic [31:0] CHUNK = 32'(MAX_CHUNK);

  typedef enum logic [1:0] {
    CS_PENDING,
    CS_OPEN,
    CS_CLOSED
  } circ_state_e;

  circ_state_e state_q, state_d;
  logic [31:0] wnd_q, wthr_q;
  logic [31:0] inflight_q, inflight_d;
  logic [31:0] ungr_q, ungr_d;
  logic [31:0] credit_q, credit_d;
  logic        cblk_q, cblk_d;
  logic        kblk_q, kblk_d;
  logic        orderly_q, orderly_d;
  logic [3:0]  reason_q, reason_d;
  logic        csent_q, csent_d;
  logic        rel_q, rel_d;

  logic [31:0] cfg_wnd;
  logic [32:0] data_sum;
  logic [32:0] credit_sum;
  logic [31:0] rd_n;
  logic [32:0] ungr_sum;
  logic [31:0] ungr_sat;
  logic [PW-1:0] ungr_scaled;
  logic [31:0] budget;
  logic [31:0] taken;
  rcf_out_t    res;

  // Window 0 means the default; threshold form avoids a divider:
  // u >= W / D  <=>  D*u >= W - (D-1)
  assign cfg_wnd = (cfg_wdata_i == '0) ? DEFAULT_WINDOW : cfg_wdata_i;

  assign data_sum    = {1'b0, inflight_q} + {1'b0, ev_i.amount};
  assign credit_sum  = {1'b0, credit_q} + {1'b0, ev_i.amount};
  assign rd_n        = (ev_i.amount < inflight_q) ? ev_i.amount : inflight_q;
  assign ungr_sum    = {1'b0, ungr_q} + {1'b0, rd_n};
  assign ungr_sat    = ungr_sum[32] ? U32_MAX : ungr_sum[31:0];
  assign ungr_scaled = PW'(ungr_sat) * PW'(GRANT_DIVISOR);
  assign budget      = (credit_q < CHUNK) ? credit_q : CHUNK;
  assign taken       = (ev_i.amount < budget) ? ev_i.amount : budget;

  always_comb begin
    state_d    = state_q;
    inflight_d = inflight_q;
    ungr_d     = ungr_q;
    credit_d   = credit_q;
    cblk_d     = cblk_q;
    kblk_d     = kblk_q;
    orderly_d  = orderly_q;
    reason_d   = reason_q;
    csent_d    = csent_q;
    rel_d      = rel_q;
    res        = '0;

    case (ev_i.cmd)
      CMD_DATA: begin
        if (state_q != CS_CLOSED && ev_i.amount != '0) begin
          if (data_sum > {1'b0, wnd_q}) begin
            state_d         = CS_CLOSED;
            reason_d        = PROTOCOL_ERROR_REASON;
            orderly_d       = 1'b0;
            res.poll_events = EV_ERR;
          end else begin
            inflight_d      = data_sum[31:0];
            res.poll_events = EV_IN;
          end
        end
      end
      CMD_ACCEPT: begin
        if (state_q == CS_PENDING) begin
          state_d         = CS_OPEN;
          credit_d        = ev_i.amount;
          res.poll_events = EV_OUT;
        end
      end
      CMD_CREDIT: begin
        if (state_q != CS_CLOSED && ev_i.amount != '0) begin
          credit_d = credit_sum[32] ? U32_MAX : credit_sum[31:0];
          if (cblk_q) begin
            cblk_d = 1'b0;
            if (!kblk_q && ev_i.want_write && state_q == CS_OPEN) begin
              res.poll_events = EV_OUT;
            end
          end
        end
      end
      CMD_CLOSED: begin
        if (state_q != CS_CLOSED) begin
          state_d         = CS_CLOSED;
          reason_d        = ev_i.reason_in;
          orderly_d       = ev_i.orderly;
          res.poll_events = ev_i.orderly ? EV_IN : EV_ERR;
        end
      end
      CMD_WRITABLE: begin
        if (kblk_q) begin
          kblk_d = 1'b0;
          if (!cblk_q && ev_i.want_write && state_q == CS_OPEN) begin
            res.poll_events = EV_OUT;
          end
        end
      end
      CMD_READ: begin
        if (rd_n != '0) begin
          inflight_d   = inflight_q - rd_n;
          ungr_d       = ungr_sat;
          res.io_count = rd_n;
          if (state_q != CS_CLOSED && ungr_scaled >= PW'(wthr_q)) begin
            res.grant_valid = 1'b1;
            res.grant_bytes = ungr_sat;
            ungr_d          = '0;
          end
        end else if (state_q == CS_CLOSED) begin
          res.io_status = orderly_q ? ST_CLOSED : ST_ERROR;
        end else begin
          res.io_status = ST_BLOCK;
        end
      end
      CMD_WRITE: begin
        if (state_q == CS_CLOSED) begin
          res.io_status = ST_ERROR;
        end else if (state_q != CS_OPEN || cblk_q || kblk_q) begin
          res.io_status = ST_BLOCK;
        end else if (budget == '0) begin
          cblk_d        = 1'b1;
          res.io_status = ST_BLOCK;
        end else if (taken == '0) begin
          res.io_status = ST_BLOCK;
        end else begin
          credit_d      = credit_q - taken;
          res.data_sent = 1'b1;
          res.io_count  = taken;
          if (!ev_i.carrier_ok) begin
            kblk_d = 1'b1;
          end
        end
      end
      CMD_SHUTDOWN: begin
        if (!csent_q) begin
          csent_d            = 1'b1;
          res.close_sent_now = 1'b1;
        end
        if (state_q != CS_CLOSED) begin
          state_d   = CS_CLOSED;
          reason_d  = ev_i.reason_in;
          orderly_d = 1'b0;
        end
      end
      CMD_RELEASE: begin
        if (!rel_q) begin
          rel_d              = 1'b1;
          state_d            = CS_CLOSED;
          res.release_notice = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.close_reason = reason_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CS_PENDING;
      wnd_q      <= DEFAULT_WINDOW;
      wthr_q     <= DEFAULT_WINDOW - GD_M1;
      inflight_q <= '0;
      ungr_q     <= '0;
      credit_q   <= '0;
      cblk_q     <= 1'b0;
      kblk_q     <= 1'b0;
      orderly_q  <= 1'b0;
      reason_q   <= '0;
      csent_q    <= 1'b0;
      rel_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wnd_q  <= cfg_wnd;
        wthr_q <= (cfg_wnd > GD_M1) ? (cfg_wnd - GD_M1) : '0;
      end
      if (fire_i) begin
        state_q    <= state_d;
        inflight_q <= inflight_d;
        ungr_q     <= ungr_d;
        credit_q   <= credit_d;
        cblk_q     <= cblk_d;
        kblk_q     <= kblk_d;
        orderly_q  <= orderly_d;
        reason_q   <= reason_d;
        csent_q    <= csent_d;
        rel_q      <= rel_d;
      end
    end
  end

  assign res_o = res;

  assign status_o.closed          = (state_q == CS_CLOSED);
  assign status_o.released        = rel_q;
  assign status_o.credit_blocked  = cblk_q;
  assign status_o.carrier_blocked = kblk_q;

endmodule

// ===== hw/rtl/relay_circuit_credit_flow.sv =====
// relay_circuit_credit_flow: top level of the relayed circuit credit block.
// Input register, event engine and result register; uses rcf_pkg, rcf_engine.
// Handshakes are valid/stall on both sides; one config register.
`timescale 1ns / 1ps

// One relayed circuit with credit flow control in both directions. Every
// input transaction is one event (data arrival, accept, credit, close, carrier
// writable, read, write, shutdown, release) and produces exactly one result
// transaction. An event is held in an input register, evaluated in one pass
// of short logic against the circuit registers, and the result is captured in
// an output register; the state update happens in the same cycle the result
// is captured. Throughput is one transaction per clock while the downstream
// side does not stall, set by the single evaluation pass; the input register
// feeds the result register, and a downstream stall can hold the event in
// either. While the result register holds an untaken result and the
// downstream side stalls, the input register can still take one more
// transaction, so the upstream side sees stall only when both are full.
// The receive window (cfg_wdata_i, 0 selects 65536) is written with cfg_we_i
// while no transaction is in flight; it takes effect on the next cycle.
// Credit is granted back once ungranted bytes reach window / GRANT_DIVISOR;
// a write moves at most MAX_CHUNK bytes.
module relay_circuit_credit_flow #(
  parameter int unsigned MAX_CHUNK     = 16384,
  parameter int unsigned GRANT_DIVISOR = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rcf_pkg::rcf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rcf_pkg::rcf_out_t out_data_o
);
  import rcf_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  rcf_in_t     s1_data_q;
  logic        out_valid_q, out_valid_d;
  rcf_out_t    out_data_q;
  logic        out_free;
  logic        fire;
  logic        in_take;
  rcf_out_t    res;
  rcf_status_t status;

  // Result register can load when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // Advance the held transaction into the result register
  assign fire       = s1_valid_q && out_free;
  // Hold off upstream only while the input register cannot move
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  rcf_engine #(
    .MAX_CHUNK     (MAX_CHUNK),
    .GRANT_DIVISOR (GRANT_DIVISOR)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .ev_i        (s1_data_q),
    .res_o       (res),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on handshake, otherwise hold
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A released circuit stays closed
  a_release_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.released |-> status.closed)
    else $error("released circuit not closed");

  // Upstream is stalled only when a transaction is held
  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free slot");

  // A grant amount appears only with a grant
  a_grant_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.grant_valid) |-> (out_data_o.grant_bytes == '0))
    else $error("grant bytes without grant");

  // A sent chunk is non-empty, within the chunk limit and reported ok
  a_chunk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.data_sent) |->
      (out_data_o.io_status == ST_OK && out_data_o.io_count != '0 &&
       out_data_o.io_count <= 32'(MAX_CHUNK)))
    else $error("bad data chunk");

  // Each fired transaction shows up as a valid result on the next cycle
  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("fired transaction lost");

endmodule

// ===== bench/relay_circuit_credit_flow_tb.sv =====
// relay_circuit_credit_flow_tb: self-checking bench for the relayed circuit credit block.
// Uses rcf_pkg for transaction types and codes; drives relay_circuit_credit_flow as dut.
// Directed script first, then random open-circuit traffic, then the close sequence.
`timescale 1ns / 1ps

module relay_circuit_credit_flow_tb;
  import rcf_pkg::*;

  localparam logic [31:0] CHUNK_MAX      = 32'd16384;
  localparam logic [31:0] GRANT_DIV      = 32'd2;
  localparam int          DRAIN_CYCLES   = 4;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          WINDOW_ITEMS   = 100;
  localparam int          TAIL_ITEMS     = 40;
  localparam int          OPEN_ROWS      = 14;

  // Command codes the block does not know
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef enum logic [1:0] {
    CKT_PENDING = 2'd0,
    CKT_OPEN    = 2'd1,
    CKT_CLOSED  = 2'd2
  } circuit_state_e;

  // One script row: the event, an optional window write ahead of it, and
  // a typed-in response where it is obvious (otherwise the predictor decides).
  typedef struct {
    rcf_in_t     ev;
    bit          set_win;
    logic [31:0] win_val;
    bit          typed;
    rcf_out_t    want;
  } script_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we      = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;
  logic     in_valid    = 1'b0;
  rcf_in_t  in_event    = '0;
  logic     out_stall   = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  rcf_out_t out_data_o;

  // Mirror of the circuit, updated once per accepted transaction
  circuit_state_e ckt_state        = CKT_PENDING;
  logic [31:0]    win              = DEFAULT_WINDOW;
  logic [31:0]    rx_in_flight     = 32'd0;
  logic [31:0]    rx_ungranted     = 32'd0;
  logic [31:0]    tx_credit        = 32'd0;
  logic           tx_credit_stall  = 1'b0;
  logic           tx_carrier_stall = 1'b0;
  logic           shut_orderly     = 1'b0;
  logic [3:0]     shut_reason      = 4'd0;
  logic           close_msg_sent   = 1'b0;
  logic           released         = 1'b0;

  rcf_out_t    pending_responses[$];
  script_row_t script[$];
  int          mismatch_count = 0;
  bit          jitter_on      = 1'b1;
  int          stall_left     = 0;

  relay_circuit_credit_flow #(
    .MAX_CHUNK    (CHUNK_MAX),
    .GRANT_DIVISOR(GRANT_DIV)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_event),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic rcf_in_t mk_ev(logic [3:0] cmd, logic [31:0] amount, logic orderly,
                                    logic [3:0] reason, logic want_w, logic ok);
    rcf_in_t e;
    e.cmd        = cmd;
    e.amount     = amount;
    e.orderly    = orderly;
    e.reason_in  = reason;
    e.want_write = want_w;
    e.carrier_ok = ok;
    return e;
  endfunction

  function automatic rcf_out_t mk_res(logic [2:0] poll, logic [31:0] count, logic [1:0] status,
                                      logic gvalid, logic [31:0] gbytes, logic sent,
                                      logic close_now, logic [3:0] reason, logic rel);
    rcf_out_t r;
    r.poll_events    = poll;
    r.io_count       = count;
    r.io_status      = status;
    r.grant_valid    = gvalid;
    r.grant_bytes    = gbytes;
    r.data_sent      = sent;
    r.close_sent_now = close_now;
    r.close_reason   = reason;
    r.release_notice = rel;
    return r;
  endfunction

  // Writable is reported only when nothing holds the sender back
  function automatic logic [2:0] send_ready_poll(logic want_w);
    if (tx_credit_stall || tx_carrier_stall || !want_w || ckt_state != CKT_OPEN)
      return EV_NONE;
    return EV_OUT;
  endfunction

  // First close wins; later ones leave reason and kind untouched
  function automatic logic [2:0] shut_circuit(logic [3:0] why, logic orderly);
    if (ckt_state == CKT_CLOSED)
      return EV_NONE;
    ckt_state    = CKT_CLOSED;
    shut_reason  = why;
    shut_orderly = orderly;
    return orderly ? EV_IN : EV_ERR;
  endfunction

  // Apply one event to the mirrored circuit and return the response it earns
  function automatic rcf_out_t circuit_response(rcf_in_t ev);
    rcf_out_t    r;
    logic [31:0] room;
    logic [31:0] moved;
    logic [31:0] budget;
    logic [31:0] taken;
    logic [32:0] sum;
    r = '0;
    case (ev.cmd)
      CMD_DATA: begin
        if (ckt_state != CKT_CLOSED && ev.amount != 32'd0) begin
          // A window shrunk below the bytes in flight leaves no room at all
          room = (win >= rx_in_flight) ? win - rx_in_flight : 32'd0;
          if (ev.amount > room) begin
            r.poll_events = shut_circuit(PROTOCOL_ERROR_REASON, 1'b0);
          end else begin
            rx_in_flight  = rx_in_flight + ev.amount;
            r.poll_events = EV_IN;
          end
        end
      end
      CMD_ACCEPT: begin
        if (ckt_state == CKT_PENDING) begin
          ckt_state     = CKT_OPEN;
          tx_credit     = ev.amount;
          r.poll_events = EV_OUT;
        end
      end
      CMD_CREDIT: begin
        if (ckt_state != CKT_CLOSED && ev.amount != 32'd0) begin
          sum       = {1'b0, tx_credit} + {1'b0, ev.amount};
          tx_credit = sum[32] ? U32_MAX : sum[31:0];
          if (tx_credit_stall) begin
            tx_credit_stall = 1'b0;
            r.poll_events   = send_ready_poll(ev.want_write);
          end
        end
      end
      CMD_CLOSED: begin
        r.poll_events = shut_circuit(ev.reason_in, ev.orderly);
      end
      CMD_WRITABLE: begin
        if (tx_carrier_stall) begin
          tx_carrier_stall = 1'b0;
          r.poll_events    = send_ready_poll(ev.want_write);
        end
      end
      CMD_READ: begin
        moved = (ev.amount < rx_in_flight) ? ev.amount : rx_in_flight;
        if (moved != 32'd0) begin
          rx_in_flight = rx_in_flight - moved;
          sum          = {1'b0, rx_ungranted} + {1'b0, moved};
          rx_ungranted = sum[32] ? U32_MAX : sum[31:0];
          // Grant back in batches, and never once the circuit is closed
          if (ckt_state != CKT_CLOSED && rx_ungranted >= win / GRANT_DIV) begin
            r.grant_valid = 1'b1;
            r.grant_bytes = rx_ungranted;
            rx_ungranted  = 32'd0;
          end
          r.io_count  = moved;
          r.io_status = ST_OK;
        end else if (ckt_state == CKT_CLOSED) begin
          r.io_status = shut_orderly ? ST_CLOSED : ST_ERROR;
        end else begin
          r.io_status = ST_BLOCK;
        end
      end
      CMD_WRITE: begin
        if (ckt_state == CKT_CLOSED) begin
          r.io_status = ST_ERROR;
        end else if (ckt_state != CKT_OPEN || tx_credit_stall || tx_carrier_stall) begin
          r.io_status = ST_BLOCK;
        end else begin
          budget = (tx_credit < CHUNK_MAX) ? tx_credit : CHUNK_MAX;
          taken  = (ev.amount < budget) ? ev.amount : budget;
          if (budget == 32'd0) begin
            tx_credit_stall = 1'b1;
            r.io_status     = ST_BLOCK;
          end else if (taken == 32'd0) begin
            r.io_status = ST_BLOCK;
          end else begin
            tx_credit   = tx_credit - taken;
            r.data_sent = 1'b1;
            if (!ev.carrier_ok)
              tx_carrier_stall = 1'b1;
            r.io_count  = taken;
            r.io_status = ST_OK;
          end
        end
      end
      CMD_SHUTDOWN: begin
        if (!close_msg_sent) begin
          close_msg_sent   = 1'b1;
          r.close_sent_now = 1'b1;
        end
        if (ckt_state != CKT_CLOSED) begin
          ckt_state    = CKT_CLOSED;
          shut_reason  = ev.reason_in;
          shut_orderly = 1'b0;
        end
      end
      CMD_RELEASE: begin
        if (!released) begin
          released         = 1'b1;
          ckt_state        = CKT_CLOSED;
          r.release_notice = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.close_reason = shut_reason;
    return r;
  endfunction

  // Byte count in [0, cap], leaning toward the edges and toward small values
  function automatic logic [31:0] pick_amount(logic [31:0] cap);
    case ($urandom_range(0, 3))
      0:       return cap;
      1:       return $urandom_range(0, cap);
      2:       return $urandom_range(0, (cap < 32'd20000) ? cap : 32'd20000);
      default: return $urandom_range(0, (cap < 32'd64) ? cap : 32'd64);
    endcase
  endfunction

  task automatic compare_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Drive one transaction, hold it until taken, then record its response
  task automatic send_event(rcf_in_t ev, bit typed, rcf_out_t typed_res);
    rcf_out_t predicted;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_event <= ev;
    do @(posedge clk_i); while (in_stall_o);
    predicted = circuit_response(ev);
    pending_responses.push_back(typed ? typed_res : predicted);
  endtask

  // Stop sending and drain every outstanding response
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    win    = (value == 32'd0) ? DEFAULT_WINDOW : value;
  endtask

  task automatic run_row(script_row_t row);
    if (row.set_win) begin
      wait_idle();
      set_window(row.win_val);
    end
    send_event(row.ev, row.typed, row.want);
  endtask

  // Output side: random stall bursts while jitter is on
  always @(posedge clk_i) begin
    if (!rst_ni || !jitter_on) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each response transaction against the oldest expectation
  always @(posedge clk_i) begin
    rcf_out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %0h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("poll_events", 32'(want.poll_events), 32'(out_data_o.poll_events));
        compare_field("io_count", want.io_count, out_data_o.io_count);
        compare_field("io_status", 32'(want.io_status), 32'(out_data_o.io_status));
        compare_field("grant_valid", 32'(want.grant_valid), 32'(out_data_o.grant_valid));
        compare_field("grant_bytes", want.grant_bytes, out_data_o.grant_bytes);
        compare_field("data_sent", 32'(want.data_sent), 32'(out_data_o.data_sent));
        compare_field("close_sent_now", 32'(want.close_sent_now),
                      32'(out_data_o.close_sent_now));
        compare_field("close_reason", 32'(want.close_reason), 32'(out_data_o.close_reason));
        compare_field("release_notice", 32'(want.release_notice),
                      32'(out_data_o.release_notice));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rcf_in_t     ev;
    logic [31:0] room;
    logic [31:0] phase_win [5];
    int          roll;

    // Opening script: pending circuit, accept, send side stalls, receive side grants
    script.push_back('{mk_ev(CMD_READ, 32'd0, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_BLOCK, 1'b0, 32'd0, 1'b0, 1'b0, 4'd0, 1'b0)});
    // data before accept counts as if open
    script.push_back('{mk_ev(CMD_DATA, 32'd100, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_IN, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0, 4'd0, 1'b0)});
    script.push_back('{mk_ev(CMD_DATA, 32'd0, 1'b1, 4'hF, 1'b1, 1'b1), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0, 4'd0, 1'b0)});
    script.push_back('{mk_ev(CMD_ACCEPT, 32'd20000, 1'b0, 4'd0, 1'b1, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_OUT, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0, 4'd0, 1'b0)});
    // largest offer is cut to one chunk
    script.push_back('{mk_ev(CMD_WRITE, U32_MAX, 1'b0, 4'd0, 1'b1, 1'b1), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, CHUNK_MAX, ST_OK, 1'b0, 32'd0, 1'b1, 1'b0, 4'd0, 1'b0)});
    script.push_back('{mk_ev(CMD_WRITE, 32'd5000, 1'b0, 4'd0, 1'b1, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_WRITE, 32'd10, 1'b0, 4'd0, 1'b1, 1'b1), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_WRITABLE, 32'd0, 1'b0, 4'd0, 1'b1, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_WRITE, 32'd10, 1'b0, 4'd0, 1'b1, 1'b1), 1'b0, 32'd0, 1'b0, '0});
    // credit saturates at all ones
    script.push_back('{mk_ev(CMD_CREDIT, U32_MAX, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_READ, U32_MAX, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_DATA, DEFAULT_WINDOW, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0,
                       1'b0, '0});
    script.push_back('{mk_ev(CMD_READ, 32'd32768, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    // unknown command: nothing but the stored reason
    script.push_back('{mk_ev(CMD_UNUSED_HI, U32_MAX, 1'b1, 4'hF, 1'b1, 1'b1), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0, 4'd0, 1'b0)});

    // Closing script: shrink the window under the bytes in flight to force an overrun
    script.push_back('{mk_ev(CMD_READ, U32_MAX, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_DATA, 32'd3, 1'b0, 4'd0, 1'b0, 1'b0), 1'b1, U32_MAX, 1'b0, '0});
    script.push_back('{mk_ev(CMD_DATA, 32'd1, 1'b0, 4'd0, 1'b0, 1'b0), 1'b1, 32'd1, 1'b1,
                       mk_res(EV_ERR, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0,
                              PROTOCOL_ERROR_REASON, 1'b0)});
    // reads while closed move bytes but grant nothing
    script.push_back('{mk_ev(CMD_READ, U32_MAX, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b0, '0});
    script.push_back('{mk_ev(CMD_READ, 32'd4, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_ERROR, 1'b0, 32'd0, 1'b0, 1'b0,
                              PROTOCOL_ERROR_REASON, 1'b0)});
    script.push_back('{mk_ev(CMD_WRITE, 32'd10, 1'b0, 4'd0, 1'b1, 1'b1), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_ERROR, 1'b0, 32'd0, 1'b0, 1'b0,
                              PROTOCOL_ERROR_REASON, 1'b0)});
    script.push_back('{mk_ev(CMD_CLOSED, 32'd0, 1'b1, 4'd9, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0,
                              PROTOCOL_ERROR_REASON, 1'b0)});
    script.push_back('{mk_ev(CMD_SHUTDOWN, 32'd0, 1'b0, 4'd7, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b1,
                              PROTOCOL_ERROR_REASON, 1'b0)});
    script.push_back('{mk_ev(CMD_RELEASE, 32'd0, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0,
                              PROTOCOL_ERROR_REASON, 1'b1)});
    script.push_back('{mk_ev(CMD_RELEASE, 32'd0, 1'b0, 4'd0, 1'b0, 1'b0), 1'b0, 32'd0, 1'b1,
                       mk_res(EV_NONE, 32'd0, ST_OK, 1'b0, 32'd0, 1'b0, 1'b0,
                              PROTOCOL_ERROR_REASON, 1'b0)});

    // Hold reset, then release it on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero write selects the default window
    set_window(32'd0);
    for (int i = 0; i < OPEN_ROWS; i++)
      run_row(script[i]);

    // Random traffic on the open circuit, one window setting per stretch.
    // Data never exceeds the room left, so the circuit stays open throughout.
    phase_win[0] = 32'd1;
    phase_win[1] = U32_MAX;
    phase_win[2] = 32'd1000;
    phase_win[3] = $urandom_range(2, 300000);
    phase_win[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      set_window(phase_win[p]);
      jitter_on = (p != 2);
      repeat (WINDOW_ITEMS) begin
        ev.orderly    = 1'($urandom_range(0, 1));
        ev.reason_in  = 4'($urandom_range(0, 15));
        ev.want_write = 1'($urandom_range(0, 1));
        ev.carrier_ok = ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          room      = (win >= rx_in_flight) ? win - rx_in_flight : 32'd0;
          ev.cmd    = CMD_DATA;
          ev.amount = pick_amount(room);
        end else if (roll < 50) begin
          ev.cmd    = CMD_READ;
          ev.amount = pick_amount(U32_MAX);
        end else if (roll < 72) begin
          ev.cmd    = CMD_WRITE;
          ev.amount = pick_amount(U32_MAX);
        end else if (roll < 84) begin
          ev.cmd    = CMD_CREDIT;
          ev.amount = pick_amount(U32_MAX);
        end else if (roll < 94) begin
          ev.cmd    = CMD_WRITABLE;
          ev.amount = $urandom;
        end else if (roll < 97) begin
          ev.cmd    = CMD_ACCEPT;
          ev.amount = $urandom;
        end else begin
          ev.cmd    = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
          ev.amount = $urandom;
        end
        send_event(ev, 1'b0, '0);
      end
    end

    for (int i = OPEN_ROWS; i < script.size(); i++)
      run_row(script[i]);

    // Closed circuit: noise of every command, no idling on either side
    jitter_on = 1'b0;
    repeat (TAIL_ITEMS) begin
      ev.cmd        = 4'($urandom_range(0, 15));
      ev.amount     = $urandom;
      ev.orderly    = 1'($urandom_range(0, 1));
      ev.reason_in  = 4'($urandom_range(0, 15));
      ev.want_write = 1'($urandom_range(0, 1));
      ev.carrier_ok = 1'($urandom_range(0, 1));
      send_event(ev, 1'b0, '0);
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rcf_pkg.sv
hw/rtl/rcf_engine.sv
hw/rtl/relay_circuit_credit_flow.sv
bench/relay_circuit_credit_flow_tb.sv
